// ----- rtl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam int WordWidth = 32;
   localparam int CountWidth = 61;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_done;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic absorb;      // absorb the accepted input transaction
      logic spill;       // absorb the bytes left over from a block boundary
      logic pad_start;   // write 0x80 and zero fill from the current position
      logic pad_length;  // write the bit length into words 14 and 15
      logic clear_tail;  // zero the whole buffer (extra padding block)
      logic comp_start;  // load working registers, begin expansion
      logic round;       // perform one round
      logic comp_end;    // fold working registers into chaining value
      logic restart;     // reset chaining value and count
   } cmd_type;

   typedef struct packed {
      logic       block_full;  // absorb filled position 63
      logic       has_spill;   // bytes are left over for the next block
      logic       tail_long;   // padding start position above 55
      logic       last_round;  // round index is 63
   } sts_type;

   localparam word_type TjLow  = 32'h79CC4519;
   localparam word_type TjHigh = 32'h7A879D8A;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] TailLimit = 6'd55;

   localparam word_type Iv [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

   function automatic word_type rol(input word_type x, input logic [4:0] n);
      rol = (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type p0(input word_type x);
      p0 = x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
   endfunction

   function automatic word_type p1(input word_type x);
      p1 = x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
   endfunction

endpackage

// ----- rtl/sm3_datapath.sv -----
// ----------------------------------------------------------------------------
// SM3 datapath
// Block buffer, byte packing, padding, message expansion window and the
// round unit with the chaining value.
// ----------------------------------------------------------------------------
module sm3_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sm3_pkg::req_type req_data,
   input  sm3_pkg::cmd_type cmd,
   input  logic [2:0]       out_index,
   output sm3_pkg::sts_type sts,
   output sm3_pkg::word_type out_word
);
   import sm3_pkg::*;

   word_type buf_ff [16];
   word_type buf_in [16];
   word_type win_ff [16];
   word_type win_in [16];
   word_type cv_ff [8];
   word_type cv_in [8];
   word_type wr_ff [8];
   word_type wr_in [8];
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [5:0] rnd_ff, rnd_in;
   word_type spill_word_ff, spill_word_in;
   logic [2:0] spill_nb_ff, spill_nb_in;

   logic [2:0] nb;
   logic [2:0] src_nb;
   logic [2:0] take;
   word_type src_word;
   logic [5:0] pos0;
   logic [6:0] room;
   logic [6:0] endpos;
   word_type w16, a12, ss1, ss2, ff, gg, tt1, tt2, kr;
   logic [63:0] bits;

   assign nb = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
   assign src_word = cmd.spill ? spill_word_ff : req_data.message_word;
   assign src_nb = cmd.spill ? spill_nb_ff : nb;
   assign pos0 = cnt_ff[5:0];
   assign room = 7'd64 - {1'b0, pos0};
   assign take = ({4'b0, src_nb} > room) ? room[2:0] : src_nb;
   assign endpos = {1'b0, pos0} + {4'b0, src_nb};
   assign bits = {cnt_ff, 3'b000};
   assign sts.block_full = (cmd.absorb || cmd.spill) && endpos[6];
   assign sts.has_spill = (spill_nb_ff != 3'd0);
   assign sts.tail_long = pos0 > TailLimit;
   assign sts.last_round = (rnd_ff == 6'd63);
   assign out_word = cv_ff[out_index];

   assign w16 = p1(win_ff[0] ^ win_ff[7] ^ rol(win_ff[13], 5'd15))
      ^ rol(win_ff[3], 5'd7) ^ win_ff[10];
   assign kr = rol((rnd_ff < 6'd16) ? TjLow : TjHigh, rnd_ff[4:0]);
   assign a12 = rol(wr_ff[0], 5'd12);
   assign ss1 = rol(a12 + wr_ff[4] + kr, 5'd7);
   assign ss2 = ss1 ^ a12;
   always_comb begin
      if (rnd_ff < 6'd16) begin
         ff = wr_ff[0] ^ wr_ff[1] ^ wr_ff[2];
         gg = wr_ff[4] ^ wr_ff[5] ^ wr_ff[6];
      end else begin
         ff = (wr_ff[0] & wr_ff[1]) | (wr_ff[0] & wr_ff[2]) | (wr_ff[1] & wr_ff[2]);
         gg = (wr_ff[4] & wr_ff[5]) | (~wr_ff[4] & wr_ff[6]);
      end
   end
   assign tt1 = ff + wr_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
   assign tt2 = gg + wr_ff[7] + ss1 + win_ff[0];

   always_comb begin
      logic [5:0] p;
      logic [1:0] bsel;
      logic [3:0] wi;
      buf_in = buf_ff;
      win_in = win_ff;
      cv_in = cv_ff;
      wr_in = wr_ff;
      cnt_in = cnt_ff;
      rnd_in = rnd_ff;
      spill_word_in = spill_word_ff;
      spill_nb_in = spill_nb_ff;
      p = pos0;
      wi = '0;
      bsel = '0;
      if (cmd.absorb || cmd.spill) begin
         for (int i = 0; i < 4; i++) begin
            if (3'(i) < take) begin
               wi = p[5:2];
               bsel = p[1:0];
               if (bsel == 2'd0)
                  buf_in[wi] = {src_word[31-8*i -: 8], 24'h0};
               else
                  buf_in[wi][31-8*bsel -: 8] = src_word[31-8*i -: 8];
               p = p + 6'd1;
            end
         end
         cnt_in = cnt_ff + CountWidth'(take);
         spill_word_in = src_word << {take, 3'b000};
         spill_nb_in = src_nb - take;
      end
      if (cmd.pad_start) begin
         for (int j = 0; j < 16; j++) begin
            if (4'(j) > pos0[5:2]) buf_in[j] = '0;
         end
         wi = pos0[5:2];
         case (pos0[1:0])
            2'd0: buf_in[wi] = {PadByte, 24'h0};
            2'd1: buf_in[wi] = {buf_ff[wi][31:24], PadByte, 16'h0};
            2'd2: buf_in[wi] = {buf_ff[wi][31:16], PadByte, 8'h0};
            default: buf_in[wi] = {buf_ff[wi][31:8], PadByte};
         endcase
      end
      if (cmd.clear_tail) begin
         for (int j = 0; j < 16; j++) buf_in[j] = '0;
      end
      if (cmd.pad_length) begin
         buf_in[14] = bits[63:32];
         buf_in[15] = bits[31:0];
      end
      if (cmd.comp_start) begin
         win_in = buf_ff;
         wr_in = cv_ff;
         rnd_in = '0;
      end
      if (cmd.round) begin
         for (int j = 0; j < 15; j++) win_in[j] = win_ff[j+1];
         win_in[15] = w16;
         wr_in[3] = wr_ff[2];
         wr_in[2] = rol(wr_ff[1], 5'd9);
         wr_in[1] = wr_ff[0];
         wr_in[0] = tt1;
         wr_in[7] = wr_ff[6];
         wr_in[6] = rol(wr_ff[5], 5'd19);
         wr_in[5] = wr_ff[4];
         wr_in[4] = p0(tt2);
         rnd_in = rnd_ff + 6'd1;
      end
      if (cmd.comp_end) begin
         for (int j = 0; j < 8; j++) cv_in[j] = cv_ff[j] ^ wr_ff[j];
      end
      if (cmd.restart) begin
         cv_in = Iv;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      win_ff <= win_in;
      if (reset) begin
         cv_ff <= Iv;
         wr_ff <= '{default: '0};
         cnt_ff <= '0;
         rnd_ff <= '0;
         spill_word_ff <= '0;
         spill_nb_ff <= '0;
      end else begin
         cv_ff <= cv_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
         rnd_ff <= rnd_in;
         spill_word_ff <= spill_word_in;
         spill_nb_ff <= spill_nb_in;
      end
   end

endmodule

// ----- rtl/sm3_control.sv -----
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences absorption, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sm3_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_final,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sm3_pkg::sts_type sts,
   output sm3_pkg::cmd_type cmd,
   output logic [2:0]       out_index
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ROUNDS, S_FOLD, S_SPILL, S_PAD, S_LENGTH, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic fin_ff, fin_in;     // the final word has been accepted
   logic pad_ff, pad_in;     // the pad byte has been written
   logic last_ff, last_in;   // this is the final compression
   logic [2:0] idx_ff, idx_in;
   logic acc;

   assign req_ready = (state_ff == S_IDLE);
   assign acc = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_OUT);
   assign out_index = idx_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      fin_in = fin_ff;
      pad_in = pad_ff;
      last_in = last_ff;
      idx_in = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               cmd.absorb = 1'b1;
               fin_in = req_final;
               pad_in = 1'b0;
               last_in = 1'b0;
               if (sts.block_full) state_in = S_LOAD;
               else if (req_final) state_in = S_PAD;
            end
         end
         S_LOAD: begin
            cmd.comp_start = 1'b1;
            state_in = S_ROUNDS;
         end
         S_ROUNDS: begin
            cmd.round = 1'b1;
            if (sts.last_round) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.comp_end = 1'b1;
            if (last_ff) begin
               idx_in = '0;
               state_in = S_OUT;
            end else if (sts.has_spill) begin
               state_in = S_SPILL;
            end else if (fin_ff) begin
               state_in = pad_ff ? S_LENGTH : S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SPILL: begin
            cmd.spill = 1'b1;
            state_in = fin_ff ? S_PAD : S_IDLE;
         end
         S_PAD: begin
            cmd.pad_start = 1'b1;
            pad_in = 1'b1;
            if (!sts.tail_long) begin
               cmd.pad_length = 1'b1;
               last_in = 1'b1;
            end
            state_in = S_LOAD;
         end
         S_LENGTH: begin
            cmd.clear_tail = 1'b1;
            cmd.pad_length = 1'b1;
            last_in = 1'b1;
            state_in = S_LOAD;
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  fin_in = 1'b0;
                  pad_in = 1'b0;
                  last_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff <= 1'b0;
         pad_ff <= 1'b0;
         last_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         pad_ff <= pad_in;
         last_ff <= last_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- rtl/sm3_hash_engine.sv -----
// SM3 hash engine top level.
// A word that completes a block holds off further input through load, the
// rounds and fold, and through a spill when bytes pass the block boundary;
// other words are accepted back to back while the controller is idle.
// Eight digest transactions follow the final word, after its padding and
// compression. Synchronous reset restores the initial value.
// ----------------------------------------------------------------------------
// SM3 hash engine
// Joins the controller and the datapath.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sm3_pkg::rsp_type rsp_data
);
   import sm3_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [2:0] out_index;
   word_type out_word;

   sm3_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_final(req_data.final_word), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts),
      .cmd(cmd), .out_index(out_index));

   sm3_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .out_index(out_index), .sts(sts), .out_word(out_word));

   assign rsp_data.digest_word = out_word;
   assign rsp_data.word_index = out_index;
   assign rsp_data.digest_done = (out_index == 3'd7);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Drives message words through the request channel, predicts each digest
// with a behavioral SM3 model and checks every digest transaction in order.
// ----------------------------------------------------------------------------
module tb;
   import sm3_pkg::*;

   localparam int LimitCycles = 1000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   sm3_hash_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   logic [31:0] chain_val [8];
   logic [31:0] msg_block [16];
   logic [60:0] byte_total;
   rsp_type     digest_queue [$];
   int          mismatches = 0;
   int          digests_seen = 0;
   int          words_sent = 0;
   int          cycle_count = 0;
   bit          stim_done = 0;
   bit          long_hold = 0;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
      bit          typed;
      logic [31:0] first_word;
   } stim_row_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      n = n % 32;
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   task automatic compress_block();
      logic [31:0] w [68];
      logic [31:0] r [8];
      logic [31:0] t, k, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++) w[j] = msg_block[j];
      for (int j = 16; j < 68; j++) begin
         t = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
         w[j] = t ^ rotl(t, 15) ^ rotl(t, 23) ^ rotl(w[j-13], 7) ^ w[j-6];
      end
      for (int j = 0; j < 8; j++) r[j] = chain_val[j];
      for (int j = 0; j < 64; j++) begin
         k = (j < 16) ? TjLow : TjHigh;
         a12 = rotl(r[0], 12);
         ss1 = rotl(a12 + r[4] + rotl(k, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = r[0] ^ r[1] ^ r[2];
            gg = r[4] ^ r[5] ^ r[6];
         end else begin
            ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            gg = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + r[7] + ss1 + w[j];
         r[3] = r[2];
         r[2] = rotl(r[1], 9);
         r[1] = r[0];
         r[0] = tt1;
         r[7] = r[6];
         r[6] = rotl(r[5], 19);
         r[5] = r[4];
         r[4] = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
      end
      for (int j = 0; j < 8; j++) chain_val[j] ^= r[j];
   endtask

   task automatic put_byte(input int pos, input logic [7:0] b);
      int sh;
      sh = 24 - 8 * (pos % 4);
      if (pos % 4 == 0) msg_block[pos/4] = 32'(b) << sh;
      else msg_block[pos/4] |= 32'(b) << sh;
   endtask

   task automatic hash_reset();
      for (int j = 0; j < 8; j++) chain_val[j] = Iv[j];
      byte_total = '0;
   endtask

   task automatic absorb_word(input req_type item);
      int nb, pos, p;
      logic [63:0] bits;
      rsp_type d;
      nb = (item.valid_bytes > 4) ? 4 : int'(item.valid_bytes);
      for (int i = 0; i < nb; i++) begin
         pos = int'(byte_total[5:0]);
         put_byte(pos, item.message_word[31-8*i -: 8]);
         byte_total = byte_total + 1;
         if (pos == 63) compress_block();
      end
      if (item.final_word) begin
         pos = int'(byte_total[5:0]);
         put_byte(pos, PadByte);
         p = pos + 1;
         if (pos > 55) begin
            for (; p < 64; p++) put_byte(p, 8'h00);
            compress_block();
            p = 0;
         end
         for (; p < 56; p++) put_byte(p, 8'h00);
         bits = {byte_total, 3'b000};
         msg_block[14] = bits[63:32];
         msg_block[15] = bits[31:0];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.digest_word = chain_val[i];
            d.word_index = 3'(i);
            d.digest_done = (i == 7);
            digest_queue.push_back(d);
         end
         hash_reset();
      end
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("sm3_hash_engine test failed");
         $finish;
      end
   end

   task automatic send_word(input req_type item);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_word(item);
      words_sent++;
   endtask

   task automatic send_message(input int nwords, input bit odd_tail);
      req_type item;
      for (int i = 0; i < nwords; i++) begin
         item.message_word = $urandom;
         item.final_word = (i == nwords - 1);
         item.valid_bytes = 3'd4;
         if (item.final_word && odd_tail) item.valid_bytes = 3'($urandom_range(0, 7));
         else if (!item.final_word && $urandom_range(0, 15) == 0)
            item.valid_bytes = 3'($urandom_range(0, 7));
         send_word(item);
      end
   endtask

   stim_row_type directed [9] = '{
      // Empty message: padding only; first digest word is the known SM3 value.
      '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h1AB21D83},
      // "abc"
      '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'h66C7F0F4},
      '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, 32'h0},
      '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
      '{32'hA5A5A5A5, 3'd7, 1'b1, 1'b0, 32'h0},
      '{32'h12345678, 3'd5, 1'b0, 1'b0, 32'h0},
      '{32'h9ABCDEF0, 3'd1, 1'b0, 1'b0, 32'h0},
      '{32'h5A5A5A5A, 3'd2, 1'b0, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 3'd6, 1'b1, 1'b0, 32'h0}
   };

   initial begin
      req_type item;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hash_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         item.message_word = directed[i].word;
         item.valid_bytes = directed[i].nbytes;
         item.final_word = directed[i].last;
         send_word(item);
         if (directed[i].typed && digest_queue.size() >= 8)
            digest_queue[digest_queue.size()-8].digest_word = directed[i].first_word;
      end
      // Tails just below and above the 55-byte padding boundary.
      for (int m = 13; m <= 16; m++) send_message(m, 1);
      // Long receiver hold-off on a digest, then a long message.
      long_hold = 1;
      send_message(20, 0);
      while (words_sent < 160) begin
         n = 160 - words_sent;
         if (n > 20) n = 20;
         send_message($urandom_range(1, n), $urandom_range(0, 1));
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      int gap;
      rsp_type want;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (long_hold) begin
            gap = 400;
            long_hold = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", rsp_data);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     want.digest_word, want.word_index, want.digest_done,
                     rsp_data.digest_word, rsp_data.word_index, rsp_data.digest_done);
            end
            if (want.digest_done) digests_seen++;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d message words; checked %0d digests.", words_sent, digests_seen);
      $display("Mismatches: %0d.", mismatches);
      if (mismatches == 0) $display("sm3_hash_engine test passed");
      else $display("sm3_hash_engine test failed");
      $finish;
   end

endmodule
